FILE: rtl/core/soa_pkg.sv
// Package: shared constants, types and helpers for the slab object allocator.
package soa_pkg;

    localparam int NUM_SLABS_DEF = 16;
    localparam int OBJ_MAX_DEF   = 64;
    localparam int CMD_W         = 1;
    localparam int SLAB_W        = 4;
    localparam int OBJ_W         = 6;
    localparam int CFG_W         = 7;
    localparam int TOTAL_W       = 11;
    localparam int USE_W         = 5;
    localparam int STATUS_W      = 2;
    localparam logic [CFG_W-1:0] OBJS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] MIN_OBJS   = 7'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC   = 2'd0,
        ST_FREED   = 2'd1,
        ST_RELEASE = 2'd2,
        ST_NOMEM   = 2'd3
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHAIN,
        S_EXEC,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/soa_chain_mem.sv
// Module: next-free link memory, one word per object of every slab frame.
module soa_chain_mem #(
    parameter int DEPTH = soa_pkg::NUM_SLABS_DEF * soa_pkg::OBJ_MAX_DEF,
    parameter int WIDTH = soa_pkg::CFG_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/slab_object_allocator_top.sv
// Top level: slab object allocator with stream command and result channels.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_axis_tvalid/tready tdata[0]=command [4:1]=free_slab [10:5]=free_index
//  m_axis    out  m_axis_tvalid/tready tdata[1:0]=status [5:2]=got_slab [11:6]=got_object
//                                      [22:12]=free_total [27:23]=slabs_in_use
//  cfg       in   i_cfg_we             i_cfg_wdata = objects_per_slab
//
// One transaction at a time. A free or an allocate from a partial slab passes the
// accept state, a state that checks the request and reads the link memory, an
// update state, and the result register. An allocate that claims a fresh frame
// first chains objects_per_slab (clamped) links, one write a cycle, and then
// reads the new head link. The result register holds until taken; the next
// command is accepted in the cycle after that. Reset is synchronous, active low,
// and clears control state.
module slab_object_allocator_top #(
    parameter int NUM_SLABS = soa_pkg::NUM_SLABS_DEF,
    parameter int OBJ_MAX   = soa_pkg::OBJ_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,   // command, free_slab, free_index
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,   // status, got_slab, got_object,
                                                      // free_total, slabs_in_use
    input  logic                      i_cfg_we,
    input  logic [soa_pkg::CFG_W-1:0] i_cfg_wdata
);
    localparam int SW  = $clog2(NUM_SLABS);
    localparam int LW  = SW + 1;                  // link with "none" marker
    localparam int OW  = $clog2(OBJ_MAX);
    localparam int CW  = OW + 1;                  // chain link with end marker
    localparam int AW  = SW + OW;
    localparam int NW  = $clog2(OBJ_MAX + 1);     // per-slab count
    localparam logic [LW-1:0] LNONE = LW'(NUM_SLABS);
    localparam logic [CW-1:0] CEND  = CW'(OBJ_MAX);

    // ---------------------------------------------------------------- config
    logic [soa_pkg::CFG_W-1:0] r_objs;
    logic [NW-1:0]             w_n;        // clamped objects per slab
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_objs <= soa_pkg::OBJS_RESET;
        end else if (i_cfg_we) begin
            r_objs <= i_cfg_wdata;
        end
    end
    always_comb begin
        if (r_objs < soa_pkg::MIN_OBJS) begin
            w_n = NW'(soa_pkg::MIN_OBJS);
        end else if (32'(r_objs) > OBJ_MAX) begin
            w_n = NW'(OBJ_MAX);
        end else begin
            w_n = NW'(r_objs);
        end
    end

    // ---------------------------------------------------- per-slab registers
    logic             r_claimed [NUM_SLABS];
    logic [CW-1:0]    r_first   [NUM_SLABS];
    logic [NW-1:0]    r_cnt     [NUM_SLABS];
    logic [LW-1:0]    r_pnext   [NUM_SLABS];
    logic [LW-1:0]    r_pprev   [NUM_SLABS];
    logic [LW-1:0]    r_head;
    logic [soa_pkg::TOTAL_W-1:0] r_total;
    logic [soa_pkg::USE_W-1:0]   r_inuse;

    // ---------------------------------------------------------------- request
    soa_pkg::t_state r_state, n_state;
    logic            r_cmd;
    logic [SW-1:0]   r_fs;
    logic [OW-1:0]   r_fo;
    logic            r_fok;
    logic [SW-1:0]   r_s;        // slab being served
    logic [OW-1:0]   r_ci;       // chain counter

    logic [3:0] w_in_fs;
    logic [5:0] w_in_fo;
    assign w_in_fs = s_axis_tdata[4:1];
    assign w_in_fo = s_axis_tdata[10:5];

    // lowest unused frame
    logic          w_have_free;
    logic [SW-1:0] w_free_idx;
    always_comb begin
        w_have_free = 1'b0;
        w_free_idx  = '0;
        for (int k = NUM_SLABS - 1; k >= 0; k--) begin
            if (!r_claimed[k]) begin
                w_have_free = 1'b1;
                w_free_idx  = SW'(k);
            end
        end
    end

    // link memory
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [CW-1:0] w_wdata, w_rdata;
    soa_chain_mem #(.DEPTH(NUM_SLABS * OBJ_MAX), .WIDTH(CW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // alloc reads link of the head slab's first free object
    logic [SW-1:0] w_hs;
    assign w_hs    = r_head[SW-1:0];
    assign w_raddr = {w_hs, r_first[w_hs][OW-1:0]};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_s, r_ci};
        w_wdata = (32'(r_ci) + 1 >= 32'(w_n)) ? CEND : CW'(32'(r_ci) + 1);
        if (r_state == soa_pkg::S_CHAIN) begin
            w_we = 1'b1;
        end else if (r_state == soa_pkg::S_EXEC && r_cmd == soa_pkg::CMD_FREE && r_fok
                     && 32'(r_cnt[r_fs]) + 1 < 32'(w_n)) begin
            w_we    = 1'b1;
            w_waddr = {r_fs, r_fo};
            w_wdata = r_first[r_fs];
        end
    end

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            soa_pkg::S_IDLE: if (s_axis_tvalid) n_state = soa_pkg::S_READ;
            soa_pkg::S_READ: begin
                if (r_cmd == soa_pkg::CMD_ALLOC && r_head == LNONE && w_have_free) begin
                    n_state = soa_pkg::S_CHAIN;
                end else begin
                    n_state = soa_pkg::S_EXEC;
                end
            end
            soa_pkg::S_CHAIN:
                if (32'(r_ci) + 1 >= 32'(w_n)) n_state = soa_pkg::S_READ;
            soa_pkg::S_EXEC: n_state = soa_pkg::S_OUT;
            soa_pkg::S_OUT:  if (m_axis_tready) n_state = soa_pkg::S_IDLE;
            default:         n_state = soa_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- outputs
    always_comb begin
        s_axis_tready = (r_state == soa_pkg::S_IDLE);
        m_axis_tvalid = (r_state == soa_pkg::S_OUT);
    end

    logic [soa_pkg::STATUS_W-1:0] r_status;
    logic [SW-1:0] r_gs;
    logic [OW-1:0] r_go;
    assign m_axis_tdata = {4'b0, r_inuse, r_total, 6'(r_go), 4'(r_gs), r_status};

    // list helpers (combinational next values within EXEC)
    logic [NW-1:0] w_cnt1;
    assign w_cnt1 = r_cnt[r_fs] + NW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= soa_pkg::S_IDLE;
            r_head  <= LNONE;
            r_total <= '0;
            r_inuse <= '0;
            for (int k = 0; k < NUM_SLABS; k++) r_claimed[k] <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                soa_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        // hold the transaction
                        r_cmd <= s_axis_tdata[0];
                        r_fs  <= SW'(w_in_fs);
                        r_fo  <= OW'(w_in_fo);
                        r_fok <= (32'(w_in_fs) < NUM_SLABS) && (32'(w_in_fo) < OBJ_MAX);
                    end
                end
                soa_pkg::S_READ: begin
                    r_ci <= '0;
                    r_s  <= w_free_idx;
                    r_fok <= r_fok && r_claimed[r_fs] && (32'(r_fo) < 32'(w_n));
                    if (r_cmd == soa_pkg::CMD_ALLOC && r_head == LNONE && w_have_free) begin
                        // claim frame and push it on the partial list
                        r_claimed[w_free_idx] <= 1'b1;
                        r_cnt[w_free_idx]     <= w_n;
                        r_first[w_free_idx]   <= '0;
                        r_pprev[w_free_idx]   <= LNONE;
                        r_pnext[w_free_idx]   <= r_head;
                        r_head  <= {1'b0, w_free_idx};
                        r_inuse <= r_inuse + 1'b1;
                        r_total <= r_total + soa_pkg::TOTAL_W'(w_n);
                    end
                end
                soa_pkg::S_CHAIN: r_ci <= r_ci + 1'b1;
                soa_pkg::S_EXEC: begin
                    r_status <= soa_pkg::ST_NOMEM;
                    r_gs <= '0;
                    r_go <= '0;
                    if (r_cmd == soa_pkg::CMD_ALLOC) begin
                        if (r_head != LNONE) begin
                            r_status <= soa_pkg::ST_ALLOC;
                            r_gs <= w_hs;
                            if (r_total != '0) r_total <= r_total - 1'b1;
                            if (r_cnt[w_hs] != '0) r_cnt[w_hs] <= r_cnt[w_hs] - 1'b1;
                            if (r_cnt[w_hs] <= NW'(1)) begin
                                // full: drop from head of the list
                                r_head <= r_pnext[w_hs];
                                if (r_pnext[w_hs] != LNONE)
                                    r_pprev[r_pnext[w_hs][SW-1:0]] <= LNONE;
                            end
                            if (r_first[w_hs] != CEND) begin
                                r_go <= r_first[w_hs][OW-1:0];
                                r_first[w_hs] <= w_rdata;
                            end
                        end
                    end else if (r_fok) begin
                        if (32'(w_cnt1) >= 32'(w_n)) begin
                            r_status <= soa_pkg::ST_RELEASE;
                            // unlink the slab
                            if (r_pprev[r_fs] != LNONE)
                                r_pnext[r_pprev[r_fs][SW-1:0]] <= r_pnext[r_fs];
                            else
                                r_head <= r_pnext[r_fs];
                            if (r_pnext[r_fs] != LNONE)
                                r_pprev[r_pnext[r_fs][SW-1:0]] <= r_pprev[r_fs];
                            r_total <= (r_total + 1'b1 >= soa_pkg::TOTAL_W'(w_cnt1))
                                     ? r_total + 1'b1 - soa_pkg::TOTAL_W'(w_cnt1) : '0;
                            if (r_inuse != '0) r_inuse <= r_inuse - 1'b1;
                            r_claimed[r_fs] <= 1'b0;
                            r_cnt[r_fs]     <= '0;
                        end else begin
                            r_status <= soa_pkg::ST_FREED;
                            r_total <= r_total + 1'b1;
                            r_cnt[r_fs] <= w_cnt1;
                            r_first[r_fs] <= {1'b0, r_fo};
                            if (w_cnt1 == NW'(1)) begin
                                // was full: push at head
                                r_pprev[r_fs] <= LNONE;
                                r_pnext[r_fs] <= r_head;
                                if (r_head != LNONE) r_pprev[w_hs] <= {1'b0, r_fs};
                                r_head <= {1'b0, r_fs};
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- assertions
    a_one_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");
    a_inuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_inuse) <= NUM_SLABS)
        else $error("slab count overflow");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != LNONE) |-> r_claimed[w_hs])
        else $error("partial head not claimed");
endmodule
